[hw/rtl/scancode_to_ascii_queue_defines.svh]
// Assertion macros for the scancode-to-ASCII queue RTL.
// Included by s2aq_back, the module that carries concurrent assertions; no other dependencies.
`ifndef SCANCODE_TO_ASCII_QUEUE_DEFINES_SVH
`define SCANCODE_TO_ASCII_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define S2AQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2aq assertion failed");

// Next-cycle implication, disabled while reset is high.
`define S2AQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2aq assertion failed");

`endif

[hw/rtl/s2aq_pkg.sv]
// Shared types, constants and key tables for the scancode-to-ASCII queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package s2aq_pkg;

   localparam int RING_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int KEY_COUNT          = 58;
   localparam int CHAR_W             = 7;
   localparam int RSP_W              = 16;

   localparam logic       KIND_SCAN    = 1'b0;
   localparam logic       KIND_READ    = 1'b1;
   localparam logic [7:0] RELEASE_MASK = 8'h80;
   localparam logic [6:0] KEY_MASK     = 7'h7F;

   localparam logic [6:0] CODE_LSHIFT = 7'h2A;
   localparam logic [6:0] CODE_RSHIFT = 7'h36;
   localparam logic [6:0] CODE_LCTRL  = 7'h1D;
   localparam logic [6:0] CODE_LALT   = 7'h38;
   localparam logic [6:0] CODE_CAPS   = 7'h3A;
   localparam logic [6:0] CAPS_LOW    = 7'h10;
   localparam logic [6:0] CAPS_HIGH   = 7'h32;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP
   } op_kind_type;

   typedef struct packed {
      logic caps;
      logic alt;
      logic ctrl;
      logic shift;
   } mods_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [CHAR_W-1:0]  ch;
      mods_type           mods;
   } op_type;

   // Packed so that the character sits in the lowest bits.
   typedef struct packed {
      logic              caps_on;
      logic              alt_held;
      logic              ctrl_held;
      logic              shift_held;
      logic              key_waiting;
      logic              char_valid;
      logic [CHAR_W-1:0] character;
   } rsp_type;

   localparam logic [CHAR_W-1:0] LOWER_MAP [KEY_COUNT] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   localparam logic [CHAR_W-1:0] UPPER_MAP [KEY_COUNT] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

endpackage

`default_nettype wire

[hw/rtl/s2aq_front.sv]
// Front end: takes request beats, tracks modifier keys and translates presses.
// Depends on s2aq_pkg for the key codes, the key tables and the operation type.
`timescale 1ns / 1ps
`default_nettype none

module s2aq_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic              in_kind,
   input  wire logic [7:0]        in_scan,
   input  wire logic              in_ready,
   output s2aq_pkg::op_type       op_out
);

   s2aq_pkg::mods_type mods_ff;
   s2aq_pkg::mods_type mods_in;
   logic [6:0]         key;
   logic               released;
   logic               upper;
   logic [s2aq_pkg::CHAR_W-1:0] lookup;

   assign key      = in_scan[6:0] & s2aq_pkg::KEY_MASK;
   assign released = (in_scan & s2aq_pkg::RELEASE_MASK) != 8'h00;

   // Caps lock swaps the case only across the letter rows.
   always_comb begin
      upper  = mods_ff.shift;
      lookup = '0;
      if (mods_ff.caps && (key inside {[s2aq_pkg::CAPS_LOW:s2aq_pkg::CAPS_HIGH]})) begin
         upper = !mods_ff.shift;
      end
      if (key < 7'(s2aq_pkg::KEY_COUNT)) begin
         lookup = upper ? s2aq_pkg::UPPER_MAP[key[5:0]] : s2aq_pkg::LOWER_MAP[key[5:0]];
      end
   end

   always_comb begin
      mods_in     = mods_ff;
      op_out.kind = s2aq_pkg::OP_NONE;
      op_out.ch   = lookup;
      if (in_kind == s2aq_pkg::KIND_READ) begin
         op_out.kind = s2aq_pkg::OP_POP;
      end else if (key inside {s2aq_pkg::CODE_LSHIFT, s2aq_pkg::CODE_RSHIFT}) begin
         mods_in.shift = !released;
      end else if (key == s2aq_pkg::CODE_LCTRL) begin
         mods_in.ctrl = !released;
      end else if (key == s2aq_pkg::CODE_LALT) begin
         mods_in.alt = !released;
      end else if (key == s2aq_pkg::CODE_CAPS) begin
         if (!released) begin
            mods_in.caps = !mods_ff.caps;
         end
      end else if (!released && (lookup != '0)) begin
         op_out.kind = s2aq_pkg::OP_PUSH;
      end
      op_out.mods = mods_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= '0;
      end else if (in_valid && in_ready) begin
         mods_ff <= mods_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/s2aq_queue.sv]
// Short operation queue between the front end and the ring back end.
// Depends on s2aq_pkg for the operation type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module s2aq_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire s2aq_pkg::op_type  in_op,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output s2aq_pkg::op_type       out_op
);

   localparam int IDX_W = (s2aq_pkg::QUEUE_DEPTH > 1) ? $clog2(s2aq_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(s2aq_pkg::QUEUE_DEPTH + 1);

   s2aq_pkg::op_type entries_ff [s2aq_pkg::QUEUE_DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != CNT_W'(s2aq_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_op    = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(s2aq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(s2aq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_op;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/s2aq_back.sv]
// Back end: character ring with push and pop, and the registered response stage.
// Depends on s2aq_pkg and on the assertion macros in the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "scancode_to_ascii_queue_defines.svh"

module s2aq_back #(
   parameter int RING_DEPTH = s2aq_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   output      logic              op_ready,
   input  wire s2aq_pkg::op_type  op,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output s2aq_pkg::rsp_type      rsp
);

   localparam int PTR_W = $clog2(RING_DEPTH);

   logic [s2aq_pkg::CHAR_W-1:0] ring_mem [RING_DEPTH];
   logic [s2aq_pkg::CHAR_W-1:0] rdata_ff;
   logic [PTR_W-1:0]            wp_ff, wp_in, wp_next;
   logic [PTR_W-1:0]            rp_ff, rp_in, rp_next;
   logic                        out_valid_ff, out_valid_in;
   logic                        char_valid_ff;
   logic                        key_waiting_ff;
   s2aq_pkg::mods_type          mods_ff;
   logic                        go;
   logic                        full;
   logic                        empty;
   logic                        do_push;
   logic                        do_pop;

   // The response register is either empty or being taken this cycle.
   assign op_ready = !out_valid_ff || rsp_ready;
   assign go       = op_valid && op_ready;

   assign wp_next = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rp_next = (rp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign full    = wp_next == rp_ff;
   assign empty   = wp_ff == rp_ff;
   assign do_push = go && (op.kind == s2aq_pkg::OP_PUSH) && !full;
   assign do_pop  = go && (op.kind == s2aq_pkg::OP_POP) && !empty;

   always_comb begin
      wp_in        = do_push ? wp_next : wp_ff;
      rp_in        = do_pop ? rp_next : rp_ff;
      out_valid_in = out_valid_ff;
      if (go) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // A push is written before any pop of the same slot can read it.
   always_ff @(posedge clock) begin
      if (do_push) begin
         ring_mem[wp_ff] <= op.ch;
      end
      if (do_pop) begin
         rdata_ff <= ring_mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         char_valid_ff  <= do_pop;
         key_waiting_ff <= rp_in != wp_in;
         mods_ff        <= op.mods;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp.character   = char_valid_ff ? rdata_ff : '0;
   assign rsp.char_valid  = char_valid_ff;
   assign rsp.key_waiting = key_waiting_ff;
   assign rsp.shift_held  = mods_ff.shift;
   assign rsp.ctrl_held   = mods_ff.ctrl;
   assign rsp.alt_held    = mods_ff.alt;
   assign rsp.caps_on     = mods_ff.caps;

   `S2AQ_ASSERT_NEXT(a_full_push_dropped, clock, reset,
      go && (op.kind == s2aq_pkg::OP_PUSH) && full, $stable(wp_ff))
   `S2AQ_ASSERT_NEXT(a_empty_pop_invalid, clock, reset,
      go && (op.kind == s2aq_pkg::OP_POP) && empty, out_valid_ff && !char_valid_ff)
   `S2AQ_ASSERT_NEXT(a_stall_holds_char, clock, reset,
      out_valid_ff && !rsp_ready, out_valid_ff && $stable(rsp))
   `S2AQ_ASSERT_NOW(a_pop_needs_nonempty, clock, reset,
      do_pop, wp_ff != rp_ff)

endmodule

`default_nettype wire

[hw/rtl/scancode_to_ascii_queue.sv]
// Channel   Direction  tdata (low bit up)                                     tuser
// req       in         scan_byte[7:0]                                         kind
// rsp       out        character[6:0], char_valid, key_waiting, shift_held,   -
//                      ctrl_held, alt_held, caps_on, zero fill
// One beat is taken every cycle while the operation queue has room; each request gives
// one response, registered through the front-end queue and then the response register.
// Ring push or pop uses the ring memory's one write and one read port.
// A stalled response holds the back end; the two-entry queue then fills and req_tready
// falls. Reset is synchronous and clears the modifiers, the ring pointers and the queue.
// Depends on s2aq_pkg, s2aq_front, s2aq_queue and s2aq_back.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_queue #(
   parameter int RING_DEPTH = s2aq_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [7:0]                 req_tdata,   // scan_byte[7:0]
   input  wire logic                       req_tuser,   // kind
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [s2aq_pkg::RSP_W-1:0] rsp_tdata    // character, char_valid, key_waiting,
                                                        // shift, ctrl, alt, caps, zeros
);

   s2aq_pkg::op_type  front_op;
   s2aq_pkg::op_type  queue_op;
   s2aq_pkg::rsp_type rsp;
   logic              queue_valid;
   logic              back_ready;

   s2aq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_kind  (req_tuser),
      .in_scan  (req_tdata),
      .in_ready (req_tready),
      .op_out   (front_op)
   );

   s2aq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (front_op),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_op    (queue_op)
   );

   s2aq_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (queue_valid),
      .op_ready  (back_ready),
      .op        (queue_op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = s2aq_pkg::RSP_W'(rsp);

endmodule

`default_nettype wire

[test/scancode_to_ascii_queue_tb.sv]
// Self-checking testbench for scancode_to_ascii_queue: drives scancode and read beats,
// predicts every response from its own key tables, modifier flags and character ring.
// Depends on s2aq_pkg and the scancode_to_ascii_queue RTL.
`timescale 1ns / 1ps

module scancode_to_ascii_queue_tb;

   localparam int RING_CAP     = s2aq_pkg::RING_DEPTH_DEFAULT - 1;
   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE       = 10;

   // Plain and shifted characters for each key below KEY_COUNT.
   localparam bit [7:0] PLAIN_CHARS [s2aq_pkg::KEY_COUNT] = '{
      8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
      8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
      8'h0A, 8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", "'", 8'h60,
      8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
      "*", 8'h00, " "
   };
   localparam bit [7:0] SHIFTED_CHARS [s2aq_pkg::KEY_COUNT] = '{
      8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
      8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
      8'h0A, 8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~",
      8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
      "*", 8'h00, " "
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // scan_byte[7:0]
   logic        req_tuser = 1'b0;    // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [s2aq_pkg::RSP_W-1:0] rsp_tdata;  // character[6:0], char_valid, key_waiting,
                                           // shift_held, ctrl_held, alt_held, caps_on,
                                           // zero fill

   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int error_count       = 0;
   int cycle_count       = 0;

   // Predicted keyboard state.
   logic        shift_down = 1'b0;
   logic        ctrl_down  = 1'b0;
   logic        alt_down   = 1'b0;
   logic        caps_lock  = 1'b0;
   logic [6:0]  typed_chars [$];
   s2aq_pkg::rsp_type expected_rsp [$];

   scancode_to_ascii_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Applies one beat to the predicted state and gives the response it should produce.
   function automatic s2aq_pkg::rsp_type translate_beat(input logic kind,
                                                        input logic [7:0] code);
      s2aq_pkg::rsp_type r;
      logic [6:0]        key;
      logic              released;
      logic              upper;
      logic [7:0]        ch;
      r = '0;
      key = code[6:0];
      released = code[7];
      if (kind == s2aq_pkg::KIND_READ) begin
         if (typed_chars.size() != 0) begin
            r.character  = typed_chars.pop_front();
            r.char_valid = 1'b1;
         end
      end else if (key == s2aq_pkg::CODE_LSHIFT || key == s2aq_pkg::CODE_RSHIFT) begin
         shift_down = !released;
      end else if (key == s2aq_pkg::CODE_LCTRL) begin
         ctrl_down = !released;
      end else if (key == s2aq_pkg::CODE_LALT) begin
         alt_down = !released;
      end else if (key == s2aq_pkg::CODE_CAPS) begin
         if (!released)
            caps_lock = !caps_lock;
      end else if (!released && key < s2aq_pkg::KEY_COUNT) begin
         upper = shift_down;
         // Caps lock only swaps case on the letter rows.
         if (caps_lock && key >= s2aq_pkg::CAPS_LOW && key <= s2aq_pkg::CAPS_HIGH)
            upper = !upper;
         ch = upper ? SHIFTED_CHARS[key[5:0]] : PLAIN_CHARS[key[5:0]];
         if (ch != 8'h00 && typed_chars.size() < RING_CAP)
            typed_chars.push_back(ch[6:0]);
      end
      r.key_waiting = (typed_chars.size() != 0);
      r.shift_held  = shift_down;
      r.ctrl_held   = ctrl_down;
      r.alt_held    = alt_down;
      r.caps_on     = caps_lock;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Prediction is pushed before the check so that ordering within the edge never matters.
   always @(posedge clock) begin
      s2aq_pkg::rsp_type got;
      s2aq_pkg::rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rsp.push_back(translate_beat(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = s2aq_pkg::rsp_type'(rsp_tdata[$bits(s2aq_pkg::rsp_type)-1:0]);
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("response beat %h with none expected", rsp_tdata));
            end else begin
               want = expected_rsp.pop_front();
               if (got.character !== want.character)
                  report_mismatch($sformatf("character got %h expected %h",
                                            got.character, want.character));
               if (got.char_valid !== want.char_valid)
                  report_mismatch($sformatf("char_valid got %b expected %b",
                                            got.char_valid, want.char_valid));
               if (got.key_waiting !== want.key_waiting)
                  report_mismatch($sformatf("key_waiting got %b expected %b",
                                            got.key_waiting, want.key_waiting));
               if (got.shift_held !== want.shift_held)
                  report_mismatch($sformatf("shift_held got %b expected %b",
                                            got.shift_held, want.shift_held));
               if (got.ctrl_held !== want.ctrl_held)
                  report_mismatch($sformatf("ctrl_held got %b expected %b",
                                            got.ctrl_held, want.ctrl_held));
               if (got.alt_held !== want.alt_held)
                  report_mismatch($sformatf("alt_held got %b expected %b",
                                            got.alt_held, want.alt_held));
               if (got.caps_on !== want.caps_on)
                  report_mismatch($sformatf("caps_on got %b expected %b",
                                            got.caps_on, want.caps_on));
            end
         end
      end
   end

   // Holds one beat on the request channel until it is taken, after a random idle stretch.
   task automatic send_item(input logic kind, input logic [7:0] code);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= code;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_key(input logic [7:0] code);
      send_item(s2aq_pkg::KIND_SCAN, code);
   endtask

   task automatic send_read();
      send_item(s2aq_pkg::KIND_READ, 8'($urandom_range(255)));
   endtask

   // The extra edge lets the monitor record the last beat before the queue is inspected.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_read();
      send_item(s2aq_pkg::KIND_READ, 8'hFF);
      send_item(s2aq_pkg::KIND_READ, 8'h00);
   endtask

   task automatic test_shift_and_caps();
      send_key(8'h10);                          // plain letter
      send_key({1'b0, s2aq_pkg::CODE_LSHIFT});
      send_key(8'h10);                          // shifted letter
      send_key({1'b1, s2aq_pkg::CODE_LSHIFT});
      send_key({1'b0, s2aq_pkg::CODE_RSHIFT});
      send_key(8'h02);                          // shifted digit
      send_key({1'b1, s2aq_pkg::CODE_RSHIFT});
      send_key({1'b0, s2aq_pkg::CODE_CAPS});
      send_key({1'b1, s2aq_pkg::CODE_CAPS});    // releasing caps lock changes nothing
      send_key(8'h32);                          // last key that caps lock affects
      send_key(8'h33);                          // first key past that range
      send_key({1'b0, s2aq_pkg::CODE_LSHIFT});
      send_key(8'h10);                          // shift and caps cancel out
      send_key({1'b1, s2aq_pkg::CODE_LSHIFT});
      send_key({1'b0, s2aq_pkg::CODE_CAPS});
   endtask

   task automatic test_ctrl_alt_and_unmapped();
      send_key({1'b0, s2aq_pkg::CODE_LCTRL});
      send_key({1'b0, s2aq_pkg::CODE_LALT});
      send_key({1'b1, s2aq_pkg::CODE_LCTRL});
      send_key({1'b1, s2aq_pkg::CODE_LALT});
      send_key(8'h00);                          // table entry of zero
      send_key(8'h3B);                          // first key past the tables and caps lock
      send_key(8'h7F);
      send_key(8'h90);                          // release of an ordinary key
      send_key(8'h39);                          // last table entry
      repeat (8)
         send_read();
   endtask

   task automatic send_random_item(input int read_pct);
      logic [7:0] code;
      int         pick;
      if ($urandom_range(99) < read_pct) begin
         send_read();
      end else begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            code = 8'($urandom_range(s2aq_pkg::KEY_COUNT - 1));
         end else if (pick < 72) begin
            code = {1'b1, 7'($urandom_range(127))};
         end else if (pick < 88) begin
            case ($urandom_range(4))
               0: code = {1'b0, s2aq_pkg::CODE_LSHIFT};
               1: code = {1'b0, s2aq_pkg::CODE_RSHIFT};
               2: code = {1'b0, s2aq_pkg::CODE_LCTRL};
               3: code = {1'b0, s2aq_pkg::CODE_LALT};
               default: code = {1'b0, s2aq_pkg::CODE_CAPS};
            endcase
            code[7] = ($urandom_range(1) == 1);
         end else begin
            code = 8'($urandom_range(255));
         end
         send_key(code);
      end
   endtask

   // Typing comes in stretches: some fill the ring past capacity, others drain it dry.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      int read_pct;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      read_pct = 30;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: read_pct = 5;
               1: read_pct = 35;
               default: read_pct = 70;
            endcase
         end
         if (i == count / 2)
            wait_for_drain();
         send_random_item(read_pct);
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_read();
      test_shift_and_caps();
      test_ctrl_alt_and_unmapped();
      wait_for_drain();
      test_random_traffic(0, 0, 400);
      test_random_traffic(52, 0, 400);
      test_random_traffic(0, 52, 400);
      test_random_traffic(28, 28, 400);
      repeat (SETTLE)
         @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
